[rtl/imu_fda_pkg.sv]
// shared types, codes and helpers of the imu fifo decimating accumulator
`default_nettype none
package imu_fda_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DEC  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_DEC   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 3'd4;
	localparam int CFG_DATA_W = 16;

	// result kinds
	localparam logic [1:0] KIND_ACCEL  = 2'd0;
	localparam logic [1:0] KIND_GYRO   = 2'd1;
	localparam logic [1:0] KIND_REPORT = 2'd2;

	// pending result bits inside a bundle, in delivery order
	localparam int PEND_ACCEL  = 0;
	localparam int PEND_GYRO   = 1;
	localparam int PEND_REPORT = 2;

	// coefficient is unsigned q0.16
	localparam int ALPHA_FRAC = 16;

	localparam logic [2:0]  ACCEL_DEC_RST  = 3'd1;
	localparam logic [3:0]  GYRO_DEC_RST   = 4'd1;
	localparam logic [15:0] CLIP_LIMIT_RST = 16'd32768;
	localparam logic [15:0] ALPHA_RST      = 16'd32768;
	localparam logic [15:0] TEMP_LIMIT_RST = 16'd400;

	typedef struct packed {
		logic signed [15:0] accel_word0;
		logic signed [15:0] accel_word1;
		logic signed [15:0] accel_word2;
		logic signed [15:0] gyro_word3;
		logic signed [15:0] gyro_word4;
		logic signed [15:0] gyro_word5;
		logic signed [15:0] temp_word;
		logic signed [15:0] fresh_temp;
		logic               last_in_batch;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [19:0] sum_x;
		logic signed [19:0] sum_y;
		logic signed [19:0] sum_z;
		logic               clipped;
		logic               fifo_reset;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  accel_dec;
		logic [3:0]  gyro_dec;
		logic [15:0] clip_limit;
		logic [15:0] alpha;
		logic [15:0] temp_limit;
	} cfg_regs_t;

	// all results caused by one input item
	typedef struct packed {
		logic [2:0]         pend;
		logic signed [19:0] accel_x;
		logic signed [19:0] accel_y;
		logic signed [19:0] accel_z;
		logic signed [19:0] gyro_x;
		logic signed [19:0] gyro_y;
		logic signed [19:0] gyro_z;
		logic               clipped;
		logic               fifo_reset;
	} bundle_t;

	// true when cnt is a multiple of dv (dv nonzero)
	function automatic logic mod_zero(input logic [3:0] cnt, input logic [3:0] dv);
		logic hit;
		hit = (cnt == 4'd0);
		for (int k = 1; k < 16; k++) begin
			if (8'(k) * {4'd0, dv} == {4'd0, cnt})
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage
`default_nettype wire

[rtl/imu_fda_if.sv]
// stream and configuration channel interfaces
`default_nettype none
interface imu_fda_in_if;
	logic                  valid;
	logic                  ready;
	imu_fda_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface imu_fda_out_if;
	logic                   valid;
	logic                   ready;
	imu_fda_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface imu_fda_cfg_if;
	logic                                     valid;
	logic                                     ready;
	logic [imu_fda_pkg::CFG_IDX_W-1:0]        index;
	logic [imu_fda_pkg::CFG_DATA_W-1:0]       data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/imu_fifo_decimating_accumulator.sv]
// top level of the imu fifo decimating accumulator
// usage:
//   in  : one seven-word inertial fifo sample per transfer, plus the fresh
//         temperature register reading and the end-of-batch mark
//   out : results (decimated accel, decimated gyro, batch report), one per
//         transfer; last marks the final result caused by one sample
//   cfg : register writes, always ready; idle only, a user duty, not checked
// timing:
//   a sample is taken into the input register, processed in one pass by the
//   filter multiply and accumulate logic and stored as a result bundle;
//   the first result can transfer once its bundle is in the result queue
//   one sample per cycle is accepted while each sample yields at most one
//   result and the output is not stalled; a sample with n results needs n
//   transfers on the output, the result port is the limit then
// reset: accumulators, filter state, counters, temperature cache and flags
//   clear, registers take their defaults, the result queue empties
// stall: two bundles wait in the queue and one sample in the input register,
//   after that in.ready stays low until the final result of the oldest
//   bundle transfers
`default_nettype none
module imu_fifo_decimating_accumulator #(
	parameter int FILTER_FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	imu_fda_in_if.sink    in,
	imu_fda_out_if.source out,
	imu_fda_cfg_if.sink   cfg
);
	import imu_fda_pkg::*;

	cfg_regs_t regs;
	bundle_t   bundle;
	logic      push;
	logic      room;

	// register file; the user must write it only between batches, unchecked
	imu_fda_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// input register plus the single-pass state update
	imu_fda_core #(
		.FILTER_FRAC_BITS (FILTER_FRAC_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in),
		.regs   (regs),
		.room   (room),
		.push   (push),
		.bundle (bundle)
	);

	// result bundles queue up and drain one result per transfer
	imu_fda_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.bundle (bundle),
		.room   (room),
		.out    (out)
	);

endmodule
`default_nettype wire

[rtl/imu_fda_cfg.sv]
// configuration register file
`default_nettype none
module imu_fda_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	imu_fda_cfg_if.sink            cfg,
	output imu_fda_pkg::cfg_regs_t regs
);
	import imu_fda_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.accel_dec  <= ACCEL_DEC_RST;
			regs_q.gyro_dec   <= GYRO_DEC_RST;
			regs_q.clip_limit <= CLIP_LIMIT_RST;
			regs_q.alpha      <= ALPHA_RST;
			regs_q.temp_limit <= TEMP_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ACCEL_DEC:  regs_q.accel_dec  <= cfg.data[2:0];
				REG_GYRO_DEC:   regs_q.gyro_dec   <= cfg.data[3:0];
				REG_CLIP_LIMIT: regs_q.clip_limit <= cfg.data;
				REG_ALPHA:      regs_q.alpha      <= cfg.data;
				REG_TEMP_LIMIT: regs_q.temp_limit <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/imu_fda_core.sv]
// input register, sample state and per-item update
`default_nettype none
module imu_fda_core #(
	parameter int FILTER_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	imu_fda_in_if.sink             in,
	input  imu_fda_pkg::cfg_regs_t regs,
	input  logic                   room,
	output logic                   push,
	output imu_fda_pkg::bundle_t   bundle
);
	import imu_fda_pkg::*;

	localparam int SW = FILTER_FRAC_BITS + 18;  // filter state
	localparam int AW = FILTER_FRAC_BITS + 20;  // accel sum
	localparam int PW = SW + 17;                // filter product

	function automatic logic temp_ok(input logic signed [15:0] t,
		input logic signed [15:0] c, input logic [15:0] lim);
		logic signed [16:0] dif;
		logic [16:0]        mag;
		dif = 17'(t) - 17'(c);
		mag = (dif < 0) ? 17'(-dif) : 17'(dif);
		return mag < {1'b0, lim};
	endfunction

	logic     valid_s1;
	in_item_t item_s1;

	logic signed [SW-1:0] filt_q [3];
	logic signed [AW-1:0] acc_q [3];
	logic signed [19:0]   gacc_q [3];
	logic [2:0]           acnt_q;
	logic [3:0]           gcnt_q;
	logic signed [15:0]   ctemp_q;
	logic                 clip_q;
	logic                 abort_q;

	logic signed [16:0]   a_v [3];
	logic signed [19:0]   g_v [3];
	logic signed [SW-1:0] x_v [3];
	logic signed [SW-1:0] d_v [3];
	logic signed [PW-1:0] prod_v [3];
	logic signed [PW-1:0] step_v [3];
	logic signed [SW-1:0] nfilt_v [3];
	logic signed [AW-1:0] nacc_v [3];
	logic signed [19:0]   ngacc_v [3];
	logic [16:0]          mag_v [3];
	logic                 clip_hit;
	logic                 fail1, fail;
	logic                 even;
	logic [2:0]           acnt_inc, adec;
	logic [3:0]           gdec, gnext;
	logic                 aemit, gemit;
	logic                 clip_new;
	logic                 need_push, advance, accept;

	// temperature check, with the retry against the fresh register reading
	assign fail1 = !temp_ok(item_s1.temp_word, ctemp_q, regs.temp_limit);
	assign fail  = fail1 && !temp_ok(item_s1.temp_word, item_s1.fresh_temp, regs.temp_limit);

	always_comb begin
		a_v[0] = 17'(item_s1.accel_word1);
		a_v[1] = 17'(item_s1.accel_word0);
		a_v[2] = -17'(item_s1.accel_word2);
		g_v[0] = 20'(item_s1.gyro_word4);
		g_v[1] = 20'(item_s1.gyro_word3);
		g_v[2] = -20'(item_s1.gyro_word5);
		clip_hit = 1'b0;
		for (int i = 0; i < 3; i++) begin
			x_v[i]     = SW'(a_v[i]) <<< FILTER_FRAC_BITS;
			d_v[i]     = x_v[i] - filt_q[i];
			prod_v[i]  = PW'(d_v[i]) * PW'($signed({1'b0, regs.alpha}));
			step_v[i]  = prod_v[i] >>> ALPHA_FRAC;
			nfilt_v[i] = filt_q[i] + SW'(step_v[i]);
			nacc_v[i]  = acc_q[i] + AW'(nfilt_v[i]);
			ngacc_v[i] = gacc_q[i] + g_v[i];
			mag_v[i]   = (a_v[i] < 0) ? 17'(-a_v[i]) : 17'(a_v[i]);
			if (mag_v[i] > {1'b0, regs.clip_limit})
				clip_hit = 1'b1;
		end
	end

	// accel works on even gyro counts only
	assign even     = !gcnt_q[0];
	assign acnt_inc = acnt_q + 3'd1;
	assign adec     = (regs.accel_dec == 3'd0) ? 3'd1 : regs.accel_dec;
	assign gdec     = (regs.gyro_dec == 4'd0) ? 4'd1 : regs.gyro_dec;
	assign aemit    = even && mod_zero({1'b0, acnt_inc}, {1'b0, adec});
	assign gnext    = (aemit ? 4'd0 : gcnt_q) + 4'd1;
	assign gemit    = mod_zero(gnext, gdec);
	assign clip_new = clip_q || (even && clip_hit);

	always_comb begin
		bundle         = '0;
		bundle.accel_x = nacc_v[0][AW-1:FILTER_FRAC_BITS];
		bundle.accel_y = nacc_v[1][AW-1:FILTER_FRAC_BITS];
		bundle.accel_z = nacc_v[2][AW-1:FILTER_FRAC_BITS];
		bundle.gyro_x  = ngacc_v[0];
		bundle.gyro_y  = ngacc_v[1];
		bundle.gyro_z  = ngacc_v[2];
		if (abort_q) begin
			bundle.pend = 3'b000;
		end else if (fail) begin
			bundle.pend[PEND_REPORT] = 1'b1;
			bundle.clipped           = clip_q;
			bundle.fifo_reset        = 1'b1;
		end else begin
			bundle.pend[PEND_ACCEL]  = aemit;
			bundle.pend[PEND_GYRO]   = gemit;
			bundle.pend[PEND_REPORT] = item_s1.last_in_batch;
			bundle.clipped           = clip_new;
		end
	end

	assign need_push = bundle.pend != 3'b000;
	assign advance   = valid_s1 && (!need_push || room);
	assign push      = advance && need_push;
	assign in.ready  = !valid_s1 || advance;
	assign accept    = in.valid && in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= in.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				filt_q[i] <= '0;
				acc_q[i]  <= '0;
				gacc_q[i] <= '0;
			end
			acnt_q  <= '0;
			gcnt_q  <= '0;
			ctemp_q <= '0;
			clip_q  <= 1'b0;
			abort_q <= 1'b0;
		end else if (advance) begin
			if (abort_q) begin
				if (item_s1.last_in_batch)
					abort_q <= 1'b0;
			end else begin
				if (fail1)
					ctemp_q <= item_s1.fresh_temp;
				if (fail) begin
					clip_q  <= 1'b0;
					abort_q <= !item_s1.last_in_batch;
				end else begin
					if (even) begin
						for (int i = 0; i < 3; i++) begin
							filt_q[i] <= nfilt_v[i];
							acc_q[i]  <= aemit ? '0 : nacc_v[i];
						end
						acnt_q <= aemit ? 3'd0 : acnt_inc;
					end
					gcnt_q <= gnext;
					for (int i = 0; i < 3; i++)
						gacc_q[i] <= gemit ? '0 : ngacc_v[i];
					clip_q <= item_s1.last_in_batch ? 1'b0 : clip_new;
				end
			end
		end
	end

	a_abort_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && abort_q |-> !push)
		else $error("aborted batch produced a result");

	a_fail_aborts: assert property (@(posedge clk) disable iff (!arst_n)
		push && bundle.fifo_reset && !item_s1.last_in_batch |=> abort_q)
		else $error("temperature failure did not abort the batch");

endmodule
`default_nettype wire

[rtl/imu_fda_outq.sv]
// two-deep result bundle queue and result serializer
`default_nettype none
module imu_fda_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  imu_fda_pkg::bundle_t bundle,
	output logic                 room,
	imu_fda_out_if.source        out
);
	import imu_fda_pkg::*;

	bundle_t    ent_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	bundle_t    head;
	logic [2:0] rest;
	logic       xfer, final_res, pop;

	assign head      = ent_q[rd_q];
	assign rest      = head.pend & (head.pend - 3'd1);
	assign final_res = (rest == 3'b000);
	assign out.valid = (cnt_q != 2'd0);
	assign xfer      = out.valid && out.ready;
	assign pop       = xfer && final_res;
	assign room      = (cnt_q != 2'd2);

	always_comb begin
		out.data      = '0;
		out.data.last = final_res;
		if (head.pend[PEND_ACCEL]) begin
			out.data.kind  = KIND_ACCEL;
			out.data.sum_x = head.accel_x;
			out.data.sum_y = head.accel_y;
			out.data.sum_z = head.accel_z;
		end else if (head.pend[PEND_GYRO]) begin
			out.data.kind  = KIND_GYRO;
			out.data.sum_x = head.gyro_x;
			out.data.sum_y = head.gyro_y;
			out.data.sum_z = head.gyro_z;
		end else begin
			out.data.kind       = KIND_REPORT;
			out.data.clipped    = head.clipped;
			out.data.fifo_reset = head.fifo_reset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// push and a partial drain never hit the same entry
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= bundle;
		if (xfer && !final_res)
			ent_q[rd_q].pend <= rest;
	end

	a_head_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> head.pend != 3'b000)
		else $error("queued bundle with nothing to deliver");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("bundle pushed into a full queue");

endmodule
`default_nettype wire
